/* hdl/iorb_pkg.sv */
`default_nettype none

package iorb_pkg;

    // Default sizing of the buffer.
    localparam int SLOT_COUNT_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of a 1-based slot number that can also hold the slot count itself.
    localparam int KEY_WIDTH_DEF   = $clog2(SLOT_COUNT_DEF + 1);

endpackage

`default_nettype wire

/* hdl/iorb_if.sv */
`default_nettype none

// Input channel: one slot write per transaction.
interface iorb_in_if #(
    parameter int KEY_WIDTH   = iorb_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = iorb_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [KEY_WIDTH-1:0]   slot_key;
    logic [VALUE_WIDTH-1:0] slot_value;

    modport source (output valid, output slot_key, output slot_value, input ready);
    modport sink   (input valid, input slot_key, input slot_value, output ready);
    modport mon    (input valid, input slot_key, input slot_value, input ready);
endinterface

// Result channel: one released word, or an empty marker, per transaction.
interface iorb_out_if #(
    parameter int VALUE_WIDTH = iorb_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] out_value;
    logic                   has_value;
    logic                   last_of_run;
    logic                   bad_key;

    modport source (output valid, output out_value, output has_value,
                    output last_of_run, output bad_key, input ready);
    modport sink   (input valid, input out_value, input has_value,
                    input last_of_run, input bad_key, output ready);
    modport mon    (input valid, input out_value, input has_value,
                    input last_of_run, input bad_key, input ready);
endinterface

// Configuration channel: writes the stream length register.
interface iorb_cfg_if #(
    parameter int KEY_WIDTH = iorb_pkg::KEY_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [KEY_WIDTH-1:0] stream_length;

    modport source (output valid, output stream_length, input ready);
    modport sink   (input valid, input stream_length, output ready);
    modport mon    (input valid, input stream_length, input ready);
endinterface

`default_nettype wire

/* hdl/in_order_release_buffer.sv */
`default_nettype none

// Channel   Direction  Payload                                         Handshake
// item      in         slot_key, slot_value                            valid/ready
// result    out        out_value, has_value, last_of_run, bad_key      valid/ready
// cfg       in         stream_length                                   valid/ready
//
// An input transaction stores its slot, then releases one slot per cycle while the result
// channel is not stalled, and ends with a closing result; a bad key goes straight to a flagged close.
// The pace of the release run is set by the single read port of the slot memory.
// After reset and after every configuration write, a clearing pass sweeps every
// slot of the slot memory; item.ready stays low until it finishes.
// A stalled result channel holds the release run in place; no state is lost.

module in_order_release_buffer #(
    parameter int SLOT_COUNT  = iorb_pkg::SLOT_COUNT_DEF,
    parameter int VALUE_WIDTH = iorb_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iorb_in_if.sink    item,
    iorb_out_if.source result,
    iorb_cfg_if.sink   cfg
);
    import iorb_pkg::*;

    // A key runs from 1 to SLOT_COUNT; the release pointer may run one past that.
    localparam int KEY_W  = $clog2(SLOT_COUNT + 1);
    localparam int NR_W   = $clog2(SLOT_COUNT + 2);
    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int MEM_W  = VALUE_WIDTH + 1;

    // Controller states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // Each memory word holds the filled flag above the data word.
    logic [MEM_W-1:0]       slot_mem [SLOT_COUNT];
    logic [MEM_W-1:0]       rd_data_reg;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]       mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [1:0]             state_reg, state_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [KEY_W-1:0]       len_reg, len_next;
    logic [NR_W-1:0]        nr_reg, nr_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [VALUE_WIDTH-1:0] hold_data_reg, hold_data_next;
    logic                   fwd_reg, fwd_next;
    logic [VALUE_WIDTH-1:0] fwd_data_reg, fwd_data_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                   out_has_reg, out_has_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_bad_reg, out_bad_next;

    logic                   item_fire;
    logic                   key_ok;
    logic [KEY_W-1:0]       key_m1;
    logic [NR_W-1:0]        nr_m1;
    logic                   nr_in_range;
    logic                   nr_has_next;
    logic                   out_free;
    logic                   look_filled;
    logic [VALUE_WIDTH-1:0] look_data;
    logic                   avail;
    logic                   load_out;
    logic [KEY_W-1:0]       len_clamped;

    assign item.ready  = (state_reg == ST_IDLE);
    assign item_fire   = item.valid && item.ready;
    assign cfg.ready   = 1'b1;

    assign key_ok      = (item.slot_key != '0) && (item.slot_key <= len_reg);
    assign key_m1      = item.slot_key - KEY_W'(1);
    assign nr_m1       = nr_reg - NR_W'(1);
    assign nr_in_range = nr_reg <= NR_W'(len_reg);
    assign nr_has_next = nr_reg < NR_W'(len_reg);
    assign out_free    = !out_valid_reg || result.ready;

    // A slot written in the same cycle as its read is taken from the forward register.
    assign look_filled = fwd_reg ? 1'b1 : rd_data_reg[VALUE_WIDTH];
    assign look_data   = fwd_reg ? fwd_data_reg : rd_data_reg[VALUE_WIDTH-1:0];
    assign avail       = nr_in_range && look_filled;

    // Length writes are clamped into the range of slots that exist.
    always_comb
    begin
        if (cfg.stream_length == '0)
        begin
            len_clamped = KEY_W'(1);
        end
        else if (cfg.stream_length > KEY_W'(SLOT_COUNT))
        begin
            len_clamped = KEY_W'(SLOT_COUNT);
        end
        else
        begin
            len_clamped = cfg.stream_length;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        len_next        = len_reg;
        nr_next         = nr_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        fwd_next        = fwd_reg;
        fwd_data_next   = fwd_data_reg;

        mem_we          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = nr_m1[ADDR_W-1:0];

        load_out        = 1'b0;
        out_value_next  = out_value_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep one slot per cycle, writing an empty word.
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == ADDR_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (key_ok)
                    begin
                        // Store the slot and look up the release pointer in the same cycle.
                        mem_we          = 1'b1;
                        mem_waddr       = key_m1[ADDR_W-1:0];
                        mem_wdata       = {1'b1, item.slot_value};
                        mem_re          = nr_in_range;
                        mem_raddr       = nr_m1[ADDR_W-1:0];
                        fwd_next        = (NR_W'(item.slot_key) == nr_reg);
                        fwd_data_next   = item.slot_value;
                        hold_valid_next = 1'b0;
                        state_next      = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_BAD;
                    end
                end
            end

            ST_LOOK:
            begin
                // One released word is held back until the next slot shows whether
                // it closes the run.
                if (avail)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            load_out       = 1'b1;
                            out_value_next = hold_data_reg;
                            out_has_next   = 1'b1;
                            out_last_next  = 1'b0;
                            out_bad_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_data_next  = look_data;
                        nr_next         = nr_reg + NR_W'(1);
                        fwd_next        = 1'b0;
                        mem_re          = nr_has_next;
                        mem_raddr       = nr_reg[ADDR_W-1:0];
                    end
                end
                else if (out_free)
                begin
                    load_out        = 1'b1;
                    out_value_next  = hold_valid_reg ? hold_data_reg : '0;
                    out_has_next    = hold_valid_reg;
                    out_last_next   = 1'b1;
                    out_bad_next    = 1'b0;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_BAD:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_value_next = '0;
                    out_has_next   = 1'b0;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A length write starts a new stream and sweeps the memory again.
        if (cfg.valid)
        begin
            len_next     = len_clamped;
            nr_next      = NR_W'(1);
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            len_reg        <= KEY_W'(SLOT_COUNT);
            nr_reg         <= NR_W'(1);
            hold_valid_reg <= 1'b0;
            fwd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            len_reg        <= len_next;
            nr_reg         <= nr_next;
            hold_valid_reg <= hold_valid_next;
            fwd_reg        <= fwd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
        fwd_data_reg  <= fwd_data_next;
        out_value_reg <= out_value_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_value   = out_value_reg;
    assign result.has_value   = out_has_reg;
    assign result.last_of_run = out_last_reg;
    assign result.bad_key     = out_bad_reg;

endmodule

`default_nettype wire

/* hdl/iorb_check.sv */
`default_nettype none

module iorb_check #(
    parameter int VALUE_WIDTH = iorb_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   item_valid,
    input wire logic                   item_ready,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire logic [VALUE_WIDTH-1:0] out_value,
    input wire logic                   has_value,
    input wire logic                   last_of_run,
    input wire logic                   bad_key,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready
);

    // Every transaction on the input takes the block out of the idle state, which drops item_ready.
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken on two consecutive cycles");

    // A length write starts the clearing pass, which blocks the input.
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !item_ready)
        else $error("input open right after a length write");

    // A result without a value always closes its run.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_value |-> last_of_run)
        else $error("empty result not marked last");

    // A flagged key never carries a value.
    a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_key |-> !has_value && out_value == '0)
        else $error("bad key result carries a value");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_value)
            && $stable(has_value) && $stable(last_of_run)
            && $stable(bad_key))
        else $error("stalled result changed");

endmodule

bind in_order_release_buffer iorb_check #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_iorb_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_value    (result.out_value),
    .has_value    (result.has_value),
    .last_of_run  (result.last_of_run),
    .bad_key      (result.bad_key),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

`default_nettype wire
